/* sv/heater_ramp_phase_angle_control_core_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the heater ramp phase-angle control core
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef HEATER_RAMP_PHASE_ANGLE_CONTROL_CORE_MACROS_SVH
`define HEATER_RAMP_PHASE_ANGLE_CONTROL_CORE_MACROS_SVH

// Same-cycle implication
`define HRPAC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hrpac assertion failed");

// Next-cycle implication
`define HRPAC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hrpac assertion failed");

`endif

/* sv/hrpac_pkg.sv */
// ---------------------------------------------------------------------------
// hrpac_pkg
// Shared types and constants of the heater ramp phase-angle control core.
// ---------------------------------------------------------------------------
package hrpac_pkg;

  localparam int CHANNELS   = 3;
  localparam int ZC_W       = 3;
  localparam int TEMP_W     = 16;
  localparam int LIM_W      = 12;
  localparam int TALLY_W    = 15;
  localparam int PWR_W      = 7;
  localparam int CNT_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [CNT_W-1:0]   COUNT_CAP    = 7'd105;
  localparam logic [CNT_W-1:0]   DELAY_OFF    = 7'd110;
  localparam logic [PWR_W-1:0]   PWR_MAX      = 7'd100;
  localparam logic [PWR_W-1:0]   PWR_CLIP     = 7'd99;
  localparam logic [PWR_W-1:0]   PWR_MIN_FIRE = 7'd5;
  localparam logic [CNT_W-1:0]   DELAY_BASE   = 7'd100;
  localparam logic [TALLY_W-1:0] TALLY_MAX    = 15'd32767;
  localparam logic signed [TEMP_W-1:0] SETPOINT_NONE = -16'sd50;
  localparam logic signed [TEMP_W-1:0] TEMP_ABSENT   = -16'sd1;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_CTRL = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT_ONE   = 3'd0,
    CFG_SETPOINT_TWO   = 3'd1,
    CFG_SETPOINT_THREE = 3'd2,
    CFG_HEATER_LIMIT   = 3'd3,
    CFG_FAULT_LIMIT    = 3'd4,
    CFG_FAULT_CNT_LIM  = 3'd5,
    CFG_DOWN_STEP      = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [LIM_W-1:0] setpoint_one;
    logic signed [LIM_W-1:0] setpoint_two;
    logic signed [LIM_W-1:0] setpoint_three;
    logic signed [LIM_W-1:0] heater_limit;
    logic signed [LIM_W-1:0] fault_limit;
    logic [TALLY_W-1:0]      fault_count_limit;
    logic [PWR_W-1:0]        down_step;
  } cfg_t;

  typedef struct packed {
    logic                     kind;
    logic [ZC_W-1:0]          zero_cross;
    logic signed [TEMP_W-1:0] heater_temp;
    logic signed [TEMP_W-1:0] room_temp;
    logic [2:0]               mode_switches;
  } item_t;

  typedef struct packed {
    logic [PWR_W-1:0]   power_level;
    logic               error_flag;
    logic [TALLY_W-1:0] fault_total;
  } status_t;

endpackage

/* sv/hrpac_if.sv */
// ---------------------------------------------------------------------------
// hrpac channel interfaces
// Valid/ready channels for input items and results.
// ---------------------------------------------------------------------------
interface hrpac_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  zero_cross;
  logic signed [15:0] heater_temp;
  logic signed [15:0] room_temp;
  logic [2:0]  mode_switches;

  modport source (output valid, kind, zero_cross, heater_temp, room_temp, mode_switches,
                  input ready);
  modport sink   (input valid, kind, zero_cross, heater_temp, room_temp, mode_switches,
                  output ready);
endinterface

interface hrpac_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  gate_fire;
  logic [6:0]  power_level;
  logic        error_flag;
  logic [14:0] fault_total;

  modport source (output valid, gate_fire, power_level, error_flag, fault_total,
                  input ready);
  modport sink   (input valid, gate_fire, power_level, error_flag, fault_total,
                  output ready);
endinterface

/* sv/hrpac_cfg.sv */
// ---------------------------------------------------------------------------
// hrpac_cfg
// Configuration register file, write-only.
// ---------------------------------------------------------------------------
module hrpac_cfg
  import hrpac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  we,
  input  logic [CFG_IDX_W-1:0]  index,
  input  logic [CFG_DATA_W-1:0] wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (we) begin
      case (cfg_idx_t'(index))
        CFG_SETPOINT_ONE:   cfg_nxt.setpoint_one      = wdata[LIM_W-1:0];
        CFG_SETPOINT_TWO:   cfg_nxt.setpoint_two      = wdata[LIM_W-1:0];
        CFG_SETPOINT_THREE: cfg_nxt.setpoint_three    = wdata[LIM_W-1:0];
        CFG_HEATER_LIMIT:   cfg_nxt.heater_limit      = wdata[LIM_W-1:0];
        CFG_FAULT_LIMIT:    cfg_nxt.fault_limit       = wdata[LIM_W-1:0];
        CFG_FAULT_CNT_LIM:  cfg_nxt.fault_count_limit = wdata[TALLY_W-1:0];
        CFG_DOWN_STEP:      cfg_nxt.down_step         = wdata[PWR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint_one      <= 12'sd288;
      cfg_r.setpoint_two      <= 12'sd352;
      cfg_r.setpoint_three    <= 12'sd384;
      cfg_r.heater_limit      <= 12'sd800;
      cfg_r.fault_limit       <= 12'sd1200;
      cfg_r.fault_count_limit <= 15'd100;
      cfg_r.down_step         <= 7'd20;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* sv/hrpac_phase.sv */
// ---------------------------------------------------------------------------
// hrpac_phase
// Per-channel phase counters and gate firing.
// ---------------------------------------------------------------------------
module hrpac_phase
  import hrpac_pkg::*;

`include "heater_ramp_phase_angle_control_core_macros.svh"
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             kind,
  input  logic [ZC_W-1:0]  zero_cross,
  input  logic [CNT_W-1:0] fire_delay,
  output logic [ZC_W-1:0]  gate
);

  logic [CNT_W-1:0] cnt_r   [CHANNELS];
  logic [CNT_W-1:0] cnt_nxt [CHANNELS];
  logic [ZC_W-1:0]  gate_r;
  logic [ZC_W-1:0]  gate_nxt;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    logic [CNT_W-1:0] base;
    logic [CNT_W-1:0] tick_cnt;

    if (i < ZC_W) begin : g_zc
      assign base = zero_cross[i] ? '0 : cnt_r[i];
      // gate bit sees the count after this tick
      assign gate_nxt[i] = (kind == KIND_TICK) ? (tick_cnt == fire_delay) : gate_r[i];
    end else begin : g_nozc
      assign base = cnt_r[i];
    end

    assign tick_cnt   = (base < COUNT_CAP) ? base + 7'd1 : base;
    assign cnt_nxt[i] = (kind == KIND_TICK) ? tick_cnt : '0;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cnt_r[i] <= '0;
      end else if (step) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  for (genvar j = CHANNELS; j < ZC_W; j++) begin : g_unused
    assign gate_nxt[j] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_r <= '0;
    end else if (step) begin
      gate_r <= gate_nxt;
    end
  end

  assign gate = gate_r;

  `HRPAC_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_r[0] <= COUNT_CAP)

endmodule

/* sv/hrpac_ramp.sv */
// ---------------------------------------------------------------------------
// hrpac_ramp
// Power ramp, firing delay and sensor fault tally on control items.
// ---------------------------------------------------------------------------
module hrpac_ramp
  import hrpac_pkg::*;

`include "heater_ramp_phase_angle_control_core_macros.svh"
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  item_t            item,
  input  cfg_t             cfg,
  output logic [CNT_W-1:0] fire_delay,
  output status_t          status
);

  logic [PWR_W-1:0]   power_r,  power_nxt;
  logic [CNT_W-1:0]   delay_r,  delay_nxt;
  logic [TALLY_W-1:0] tally_r,  tally_nxt;
  logic               err_r,    err_nxt;

  logic signed [TEMP_W-1:0] target;
  logic signed [TEMP_W-1:0] heat_lim;
  logic signed [TEMP_W-1:0] fault_lim;
  logic                     up;
  logic                     heat_bad;
  logic                     room_bad;
  logic [PWR_W-1:0]         clip;
  logic [TALLY_W:0]         tally_sum;
  logic                     ctrl;

  assign ctrl      = step && (item.kind == KIND_CTRL);
  assign heat_lim  = TEMP_W'(cfg.heater_limit);
  assign fault_lim = TEMP_W'(cfg.fault_limit);

  // highest position wins; switches are active low
  always_comb begin
    if (!item.mode_switches[2]) begin
      target = TEMP_W'(cfg.setpoint_three);
    end else if (!item.mode_switches[1]) begin
      target = TEMP_W'(cfg.setpoint_two);
    end else if (!item.mode_switches[0]) begin
      target = TEMP_W'(cfg.setpoint_one);
    end else begin
      target = SETPOINT_NONE;
    end
  end

  assign up = (target > item.room_temp) && (item.room_temp != TEMP_ABSENT) &&
              (item.heater_temp < fault_lim) && (item.heater_temp != TEMP_ABSENT) &&
              (item.heater_temp < heat_lim);

  always_comb begin
    if (up) begin
      power_nxt = (power_r < PWR_MAX) ? power_r + 7'd1 : power_r;
    end else if (power_r > 7'd1) begin
      power_nxt = (power_r > cfg.down_step) ? power_r - cfg.down_step : '0;
    end else begin
      power_nxt = power_r;
    end
  end

  assign clip      = (power_nxt > PWR_CLIP) ? PWR_CLIP : power_nxt;
  assign delay_nxt = (power_nxt > PWR_MIN_FIRE) ? DELAY_BASE - clip : DELAY_OFF;

  assign heat_bad  = (item.heater_temp > fault_lim) || (item.heater_temp == TEMP_ABSENT);
  assign room_bad  = (item.room_temp > fault_lim) || (item.room_temp == TEMP_ABSENT);
  assign tally_sum = {1'b0, tally_r} + (TALLY_W+1)'(heat_bad) + (TALLY_W+1)'(room_bad);
  assign tally_nxt = (tally_sum > {1'b0, TALLY_MAX}) ? TALLY_MAX : tally_sum[TALLY_W-1:0];
  assign err_nxt   = err_r || (tally_nxt > cfg.fault_count_limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_r <= '0;
      delay_r <= DELAY_OFF;
      tally_r <= '0;
      err_r   <= 1'b0;
    end else if (ctrl) begin
      power_r <= power_nxt;
      delay_r <= delay_nxt;
      tally_r <= tally_nxt;
      err_r   <= err_nxt;
    end
  end

  assign fire_delay         = delay_r;
  assign status.power_level = power_r;
  assign status.error_flag  = err_r;
  assign status.fault_total = tally_r;

  `HRPAC_ASSERT_NXT(a_err_sticky, err_r, err_r)
  `HRPAC_ASSERT_IMP(a_delay_off, 1'b1, (power_r <= PWR_MIN_FIRE) == (delay_r == DELAY_OFF))
  `HRPAC_ASSERT_NXT(a_pwr_up_one, 1'b1, {1'b0, power_r} <= {1'b0, $past(power_r)} + 8'd1)

endmodule

/* sv/heater_ramp_phase_angle_control_core.sv */
// ---------------------------------------------------------------------------
// heater_ramp_phase_angle_control_core
// Three-channel triac phase-angle heater controller with power ramp.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake        | payload
//  in_ch    | in  | valid/ready      | kind, zero_cross, heater/room temp, switches
//  out_ch   | out | valid/ready      | gate_fire, power_level, error_flag, fault_total
//  cfg_*    | in  | write enable     | 3-bit register index, 15-bit data
//
//  One item per clock sustained while out_ch accepts; each item passes the input
//  register, then the state update which is also the result register.
//  Stalls on out_ch back up through the input register to in_ch.ready.
//  Synchronous active-low reset; no clearing pass.
// ---------------------------------------------------------------------------
module heater_ramp_phase_angle_control_core
  import hrpac_pkg::*;

`include "heater_ramp_phase_angle_control_core_macros.svh"
(
  input  logic                  clk,
  input  logic                  rst_n,
  hrpac_in_if.sink              in_ch,
  hrpac_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  item_t            item_r;
  logic             s1_valid_r, s1_valid_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             advance;
  logic             step;
  cfg_t             cfg;
  logic [CNT_W-1:0] fire_delay;
  status_t          status;
  logic [ZC_W-1:0]  gate;

  assign advance      = !out_valid_r || out_ch.ready;
  assign step         = s1_valid_r && advance;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign s1_valid_nxt = in_ch.ready ? in_ch.valid : s1_valid_r;
  assign out_valid_nxt = advance ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.kind          <= in_ch.kind;
      item_r.zero_cross    <= in_ch.zero_cross;
      item_r.heater_temp   <= in_ch.heater_temp;
      item_r.room_temp     <= in_ch.room_temp;
      item_r.mode_switches <= in_ch.mode_switches;
    end
  end

  hrpac_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  hrpac_phase u_phase (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .kind       (item_r.kind),
    .zero_cross (item_r.zero_cross),
    .fire_delay (fire_delay),
    .gate       (gate)
  );

  hrpac_ramp u_ramp (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .item       (item_r),
    .cfg        (cfg),
    .fire_delay (fire_delay),
    .status     (status)
  );

  // state registers double as the result register: they only move on step
  assign out_ch.valid       = out_valid_r;
  assign out_ch.gate_fire   = gate;
  assign out_ch.power_level = status.power_level;
  assign out_ch.error_flag  = status.error_flag;
  assign out_ch.fault_total = status.fault_total;

  `HRPAC_ASSERT_IMP(a_full_stall, s1_valid_r && out_valid_r && !out_ch.ready, !in_ch.ready)
  `HRPAC_ASSERT_IMP(a_pwr_range, out_valid_r, status.power_level <= PWR_MAX)

endmodule

/* test/tb_heater_ramp_phase_angle_control_core.sv */
// ----------------------------------------------------------------------------
// Testbench for heater_ramp_phase_angle_control_core
// Drives phase ticks and control updates through the valid/ready input
// channel, predicts every result in a behavioural model of the three phase
// counters, power ramp and fault tally, and checks each result in order.
// Limits are reprogrammed between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_heater_ramp_phase_angle_control_core;
  timeunit 1ns;
  timeprecision 1ps;
  import hrpac_pkg::*;

  localparam int IDLE_PCT     = 13;
  localparam int QUIET_LO     = 500;   // no idling on either side in this window
  localparam int QUIET_HI     = 650;
  localparam int HOLD_AT      = 100;   // receiver backs off after this many results
  localparam int HOLD_LEN     = 120;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE_TICKS = 8;

  typedef struct packed {
    logic [ZC_W-1:0]    gate;
    logic [PWR_W-1:0]   power;
    logic               err;
    logic [TALLY_W-1:0] tally;
  } heater_obs_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hrpac_in_if  in_ch();
  hrpac_out_if out_ch();

  heater_ramp_phase_angle_control_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the controller state
  cfg_t             limits;
  logic [CNT_W-1:0] phase_cnt [CHANNELS];
  logic [CNT_W-1:0] fire_at;
  logic [PWR_W-1:0] power_now;
  logic [TALLY_W-1:0] fault_tally;
  logic             err_latch;
  logic [ZC_W-1:0]  gate_now;

  item_t       item_queue [$];
  heater_obs_t expected_obs [$];
  item_t       held_item;

  int items_taken;
  int ctrl_taken;
  int results_seen;
  int gates_fired;
  int mismatches;
  int hold_left;
  bit hold_done;
  int stall_cycles;
  heater_obs_t got_obs;
  heater_obs_t want_obs;

  always #1 clk = ~clk;

  function automatic int room_target(logic [2:0] sw);
    int t;
    t = SETPOINT_NONE;
    // active low, highest position wins
    if (!sw[0]) t = $signed(limits.setpoint_one);
    if (!sw[1]) t = $signed(limits.setpoint_two);
    if (!sw[2]) t = $signed(limits.setpoint_three);
    return t;
  endfunction

  function automatic bit temp_faulty(int t);
    int absent;
    absent = TEMP_ABSENT;
    return (t > $signed(limits.fault_limit)) || (t == absent);
  endfunction

  task automatic heater_step(input item_t it);
    heater_obs_t o;
    logic [ZC_W-1:0] g;
    logic [PWR_W-1:0] p;
    int heat, room, absent, c;
    bit up;
    absent = TEMP_ABSENT;
    if (it.kind == KIND_TICK) begin
      g = '0;
      for (c = 0; c < CHANNELS; c++) begin
        if (it.zero_cross[c]) phase_cnt[c] = '0;
        if (phase_cnt[c] < COUNT_CAP) phase_cnt[c] = phase_cnt[c] + 1'b1;
        if (phase_cnt[c] == fire_at) g[c] = 1'b1;
      end
      gate_now = g;
    end else begin
      heat = $signed(it.heater_temp);
      room = $signed(it.room_temp);
      for (c = 0; c < CHANNELS; c++) phase_cnt[c] = '0;
      up = (room_target(it.mode_switches) > room) && (room != absent) &&
           (heat < $signed(limits.fault_limit)) && (heat != absent) &&
           (heat < $signed(limits.heater_limit));
      if (up) begin
        if (power_now < PWR_MAX) power_now = power_now + 1'b1;
      end else if (power_now > 1) begin
        power_now = (power_now > limits.down_step) ? power_now - limits.down_step : '0;
      end
      p = (power_now > PWR_CLIP) ? PWR_CLIP : power_now;
      fire_at = (p > PWR_MIN_FIRE) ? DELAY_BASE - p : DELAY_OFF;
      if (temp_faulty(heat) && fault_tally < TALLY_MAX) fault_tally = fault_tally + 1'b1;
      if (temp_faulty(room) && fault_tally < TALLY_MAX) fault_tally = fault_tally + 1'b1;
      if (fault_tally > limits.fault_count_limit) err_latch = 1'b1;
    end
    o.gate  = gate_now;
    o.power = power_now;
    o.err   = err_latch;
    o.tally = fault_tally;
    expected_obs.push_back(o);
  endtask

  // Sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        heater_step(held_item);
        items_taken++;
        if (held_item.kind == KIND_CTRL) ctrl_taken++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // transaction still pending, hold it
      end else if (item_queue.size() > 0 &&
                   !((items_taken < QUIET_LO || items_taken >= QUIET_HI) &&
                     $urandom_range(99) < IDLE_PCT)) begin
        held_item = item_queue.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.kind          <= held_item.kind;
        in_ch.zero_cross    <= held_item.zero_cross;
        in_ch.heater_temp   <= held_item.heater_temp;
        in_ch.room_temp     <= held_item.room_temp;
        in_ch.mode_switches <= held_item.mode_switches;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_obs.gate  = out_ch.gate_fire;
        got_obs.power = out_ch.power_level;
        got_obs.err   = out_ch.error_flag;
        got_obs.tally = out_ch.fault_total;
        results_seen++;
        if (got_obs.gate != '0) gates_fired++;
        if (expected_obs.size() == 0) begin
          $display("%0t: unexpected result gate=%b power=%0d err=%b faults=%0d",
                   $time, got_obs.gate, got_obs.power, got_obs.err, got_obs.tally);
          mismatches++;
        end else begin
          want_obs = expected_obs.pop_front();
          if (got_obs.gate !== want_obs.gate || got_obs.power !== want_obs.power ||
              got_obs.err !== want_obs.err || got_obs.tally !== want_obs.tally) begin
            $display("%0t: expected gate=%b power=%0d err=%b faults=%0d", $time,
                     want_obs.gate, want_obs.power, want_obs.err, want_obs.tally);
            $display("%0t:   actual gate=%b power=%0d err=%b faults=%0d", $time,
                     got_obs.gate, got_obs.power, got_obs.err, got_obs.tally);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (results_seen >= HOLD_AT && !hold_done) begin
        // long back-off so the core fills and stalls its input
        hold_left    <= HOLD_LEN;
        hold_done    <= 1'b1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !((results_seen < QUIET_LO || results_seen >= QUIET_HI) &&
                          $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic program_limits(cfg_t c);
    write_reg(CFG_SETPOINT_ONE,   {3'b000, c.setpoint_one});
    write_reg(CFG_SETPOINT_TWO,   {3'b000, c.setpoint_two});
    write_reg(CFG_SETPOINT_THREE, {3'b000, c.setpoint_three});
    write_reg(CFG_HEATER_LIMIT,   {3'b000, c.heater_limit});
    write_reg(CFG_FAULT_LIMIT,    {3'b000, c.fault_limit});
    write_reg(CFG_FAULT_CNT_LIM,  c.fault_count_limit);
    write_reg(CFG_DOWN_STEP,      CFG_DATA_W'(c.down_step));
    limits = c;
  endtask

  // wait until nothing is queued, offered or outstanding
  task automatic drain();
    do @(negedge clk);
    while (item_queue.size() != 0 || in_ch.valid || expected_obs.size() != 0);
  endtask

  function automatic item_t make_tick(logic [ZC_W-1:0] zc);
    item_t it;
    it.kind          = KIND_TICK;
    it.zero_cross    = zc;
    it.heater_temp   = 16'($urandom);    // ignored on ticks
    it.room_temp     = 16'($urandom);
    it.mode_switches = 3'($urandom);
    return it;
  endfunction

  function automatic item_t make_ctrl(int heat, int room, logic [2:0] sw);
    item_t it;
    it.kind          = KIND_CTRL;
    it.zero_cross    = ZC_W'($urandom);    // ignored on control updates
    it.heater_temp   = 16'(heat);
    it.room_temp     = 16'(room);
    it.mode_switches = sw;
    return it;
  endfunction

  function automatic int any_temp();
    case ($urandom_range(3))
      0: return TEMP_ABSENT;
      1: return $signed(16'($urandom));
      2: return $urandom_range(4200) - 2100;
      default: return $urandom_range(1) ? 32767 : -32768;
    endcase
  endfunction

  // control update that ramps power up, with random content
  function automatic item_t ramp_up_ctrl();
    logic [2:0] sw;
    int room, heat, lim;
    sw   = 3'($urandom);
    room = room_target(sw) - $urandom_range(1, 300);
    lim  = ($signed(limits.heater_limit) < $signed(limits.fault_limit)) ?
           $signed(limits.heater_limit) : $signed(limits.fault_limit);
    heat = lim - $urandom_range(1, 600);
    if (room == -1) room = -2;
    if (heat == -1) heat = -2;
    return make_ctrl(heat, room, sw);
  endfunction

  // bursts: one control update followed by a run of ticks
  task automatic queue_phase(int n, int up_pct, int long_pct);
    int made, run, k;
    made = 0;
    while (made < n) begin
      if ($urandom_range(99) < up_pct) item_queue.push_back(ramp_up_ctrl());
      else item_queue.push_back(make_ctrl(any_temp(), any_temp(), 3'($urandom)));
      made++;
      run = ($urandom_range(99) < long_pct) ? $urandom_range(30, 110) : $urandom_range(0, 3);
      for (k = 0; k < run && made < n; k++) begin
        item_queue.push_back(make_tick(ZC_W'(($urandom_range(99) < 10) ?
                                              $urandom_range(1, 7) : 0)));
        made++;
      end
    end
  endtask

  initial begin
    cfg_t c;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_TICK;
    in_ch.zero_cross = '0;
    in_ch.heater_temp = '0;
    in_ch.room_temp = '0;
    in_ch.mode_switches = '0;
    out_ch.ready = 1'b0;
    items_taken = 0;
    ctrl_taken = 0;
    results_seen = 0;
    gates_fired = 0;
    mismatches = 0;
    hold_left = 0;
    hold_done = 1'b0;
    stall_cycles = 0;
    limits = '{setpoint_one: 288, setpoint_two: 352, setpoint_three: 384,
               heater_limit: 800, fault_limit: 1200, fault_count_limit: 100,
               down_step: 20};
    for (int i = 0; i < CHANNELS; i++) phase_cnt[i] = '0;
    fire_at = DELAY_OFF;
    power_now = '0;
    fault_tally = '0;
    err_latch = 1'b0;
    gate_now = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: switch decoding, limits, sensor faults, unused fields
    item_queue.push_back(make_ctrl(0, 0, 3'b111));
    item_queue[0] = '{kind: KIND_TICK, zero_cross: 3'b111, heater_temp: 16'hFFFF,
                      room_temp: 16'hFFFF, mode_switches: 3'b111};
    item_queue.push_back(make_ctrl(0, -51, 3'b111));       // no switch: target -50
    item_queue.push_back(make_ctrl(799, 287, 3'b110));     // position 1
    item_queue.push_back(make_ctrl(0, 351, 3'b101));       // position 2
    item_queue.push_back(make_ctrl(0, 383, 3'b000));       // all low, position 3 wins
    item_queue.push_back(make_ctrl(-32768, 383, 3'b011));
    item_queue.push_back(make_ctrl(100, 100, 3'b110));     // power reaches firing range
    item_queue.push_back(make_tick(3'b000));
    item_queue.push_back(make_ctrl(800, 0, 3'b110));       // heater at limit, ramp down
    item_queue.push_back(make_ctrl(0, -1, 3'b110));        // room sensor absent
    item_queue.push_back(make_ctrl(-1, -1, 3'b000));       // both absent
    item_queue.push_back(make_ctrl(1200, 32767, 3'b000));  // heater at fault bound, not faulty
    item_queue.push_back(make_ctrl(1201, -32768, 3'b000));
    item_queue.push_back(make_ctrl(32767, 32767, 3'b010));
    item_queue.push_back(make_tick(3'b001));
    item_queue.push_back(make_tick(3'b010));
    item_queue.push_back(make_tick(3'b100));
    item_queue.push_back(make_tick(3'b000));
    item_queue.push_back(make_ctrl(0, -50, 3'b111));       // room equals target
    drain();

    // Top of range everywhere
    program_limits('{setpoint_one: 2047, setpoint_two: 2047, setpoint_three: 2047,
                     heater_limit: 2047, fault_limit: 2047, fault_count_limit: 32767,
                     down_step: 127});
    queue_phase(200, 85, 40);
    drain();

    c.setpoint_one      = 12'($urandom);
    c.setpoint_two      = 12'($urandom);
    c.setpoint_three    = 12'($urandom);
    c.heater_limit      = 12'($urandom);
    c.fault_limit       = 12'($urandom);
    c.fault_count_limit = 15'($urandom);
    c.down_step         = 7'($urandom);
    program_limits(c);
    queue_phase(150, 70, 10);
    drain();

    // Gentle ramp, dense control updates to drive power to full scale
    c = '{setpoint_one: 288, setpoint_two: 352, setpoint_three: 384, heater_limit: 800,
          fault_limit: 1200, fault_count_limit: 15'($urandom_range(200, 2000)),
          down_step: 1};
    program_limits(c);
    queue_phase(300, 97, 0);
    drain();
    queue_phase(150, 90, 50);   // long tick runs at high power
    drain();

    // Bottom of range: zero down step holds power, any fault latches the error
    program_limits('{setpoint_one: -2048, setpoint_two: -2048, setpoint_three: -2048,
                     heater_limit: -2048, fault_limit: -2048, fault_count_limit: 0,
                     down_step: 0});
    queue_phase(150, 60, 20);
    drain();

    repeat (SETTLE_TICKS) @(posedge clk);
    if (expected_obs.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_obs.size());
      mismatches++;
    end
    $display("Checked %0d results from %0d transactions (%0d control updates).",
             results_seen, items_taken, ctrl_taken);
    $display("Gate pulses seen on %0d results; final power %0d, fault tally %0d.",
             gates_fired, power_now, fault_tally);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/hrpac_pkg.sv
sv/hrpac_if.sv
sv/hrpac_cfg.sv
sv/hrpac_phase.sv
sv/hrpac_ramp.sv
sv/heater_ramp_phase_angle_control_core.sv
test/tb_heater_ramp_phase_angle_control_core.sv
